@@ hw/rtl/pst_pkg.sv @@
`default_nettype none
package pst_pkg;
    localparam logic [1:0] MODE_UPDATE = 2'd0;
    localparam logic [1:0] MODE_LOOKUP = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    localparam logic [2:0] ST_UPDATED   = 3'd0;
    localparam logic [2:0] ST_ADDED     = 3'd1;
    localparam logic [2:0] ST_REJECTED  = 3'd2;
    localparam logic [2:0] ST_FOUND     = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_CLEARED   = 3'd5;

    localparam int ENTRY_W = 40;

    typedef struct packed {
        logic [15:0] nb;
        logic [15:0] rk;
        logic [7:0]  ds;
    } entry_t;
endpackage
`default_nettype wire

@@ hw/rtl/pst_ram.sv @@
`default_nettype none
module pst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ hw/rtl/parent_set_table_top.sv @@
// channel | signals                                    | direction
// in      | in_valid in_stall mode neighbor_id rank dtsn | input beat
// out     | out_valid out_stall status ...             | result beat
// cfg     | cfg_we cfg_data (max_parents)              | write only
// One beat at a time: a scan of the entries through the one RAM read port,
// a decide/write step, an optional close-up pass after an eviction, then a
// scan for the preferred parent and the result state; a clear goes straight
// to the preferred-parent scan with the count cleared.
// Reset empties the table at once by clearing the count; RAM needs no pass.
// in_stall is high from acceptance until the result beat is taken.
`default_nettype none
module parent_set_table_top
    import pst_pkg::*;
#(
    parameter int MAX_ENTRIES = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [3:0]  cfg_data,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  mode,
    input  wire logic [15:0] neighbor_id,
    input  wire logic [15:0] rank,
    input  wire logic [7:0]  dtsn,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       status,
    output logic [15:0]      found_rank,
    output logic [7:0]       found_dtsn,
    output logic             pref_valid,
    output logic [15:0]      pref_neighbor,
    output logic [7:0]       pref_dtsn,
    output logic [16:0]      dodag_rank,
    output logic [3:0]       parent_count
);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int RD = 1 << AW;
    localparam logic [CW-1:0] MAXC = CW'(MAX_ENTRIES);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_PREF  = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [3:0]    maxp_reg;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic [CW-1:0] wptr_reg, wptr_next;
    logic          rdv_reg, rdv_next;
    logic [1:0]    md_reg, md_next;
    entry_t        cand_reg, cand_next;
    logic          hit_reg, hit_next;
    logic [CW-1:0] hidx_reg, hidx_next;
    entry_t        hent_reg, hent_next;
    logic          worse_reg, worse_next;
    logic [CW-1:0] widx_reg, widx_next;
    logic [15:0]   wrk_reg, wrk_next;
    entry_t        best_reg, best_next;
    logic [2:0]    st_reg, st_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    entry_t        wdata, rdata;
    logic [CW-1:0] cap;

    pst_ram #(.WIDTH(ENTRY_W), .DEPTH(RD)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    always_comb
    begin
        if (maxp_reg == 4'd0)
            cap = CW'(1);
        else if ({{CW{1'b0}}, maxp_reg} > {4'd0, MAXC})
            cap = MAXC;
        else
            cap = CW'(maxp_reg);
    end

    assign raddr = ptr_reg[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        wptr_next  = wptr_reg;
        rdv_next   = 1'b0;
        md_next    = md_reg;
        cand_next  = cand_reg;
        hit_next   = hit_reg;
        hidx_next  = hidx_reg;
        hent_next  = hent_reg;
        worse_next = worse_reg;
        widx_next  = widx_reg;
        wrk_next   = wrk_reg;
        best_next  = best_reg;
        st_next    = st_reg;
        we         = 1'b0;
        waddr      = wptr_reg[AW-1:0];
        wdata      = cand_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    md_next    = mode;
                    cand_next  = '{nb: neighbor_id, rk: rank, ds: dtsn};
                    hit_next   = 1'b0;
                    worse_next = 1'b0;
                    widx_next  = '0;
                    wrk_next   = '0;
                    ptr_next   = '0;
                    if (mode == MODE_CLEAR)
                    begin
                        count_next = '0;
                        st_next    = ST_CLEARED;
                        state_next = S_PREF;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (rdv_reg)
                begin
                    if (!hit_reg && rdata.nb == cand_reg.nb)
                    begin
                        hit_next  = 1'b1;
                        hidx_next = ptr_reg - CW'(1);
                        hent_next = rdata;
                    end
                    if (rdata.rk > cand_reg.rk)
                        worse_next = 1'b1;
                    if (ptr_reg == CW'(1) || rdata.rk > wrk_reg)
                    begin
                        widx_next = ptr_reg - CW'(1);
                        wrk_next  = rdata.rk;
                    end
                end
                if (ptr_reg < count_reg)
                begin
                    ptr_next = ptr_reg + CW'(1);
                    rdv_next = 1'b1;
                end
                else
                begin
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                ptr_next = '0;
                state_next = S_PREF;
                if (md_reg != MODE_UPDATE)
                begin
                    st_next = hit_reg ? ST_FOUND : ST_NOT_FOUND;
                end
                else if (hit_reg)
                begin
                    we = 1'b1;
                    waddr = hidx_reg[AW-1:0];
                    wdata = '{nb: cand_reg.nb, rk: cand_reg.rk, ds: cand_reg.ds};
                    st_next = ST_UPDATED;
                end
                else if (count_reg >= cap)
                begin
                    if (!worse_reg)
                        st_next = ST_REJECTED;
                    else
                    begin
                        st_next = ST_ADDED;
                        ptr_next = widx_reg + CW'(1);
                        wptr_next = widx_reg;
                        state_next = S_SHIFT;
                    end
                end
                else
                begin
                    st_next = ST_ADDED;
                    if (count_reg < MAXC)
                    begin
                        we = 1'b1;
                        waddr = count_reg[AW-1:0];
                        count_next = count_reg + CW'(1);
                    end
                end
            end
            S_SHIFT:
            begin
                // close up after eviction, then append at the tail
                if (rdv_reg)
                begin
                    we = 1'b1;
                    wdata = rdata;
                    wptr_next = wptr_reg + CW'(1);
                end
                if (ptr_reg < count_reg)
                begin
                    ptr_next = ptr_reg + CW'(1);
                    rdv_next = 1'b1;
                end
                else if (!rdv_reg)
                begin
                    we = 1'b1;
                    wdata = cand_reg;
                    ptr_next = '0;
                    state_next = S_PREF;
                end
            end
            S_PREF:
            begin
                if (rdv_reg)
                begin
                    if (ptr_reg == CW'(1) || rdata.rk < best_reg.rk)
                        best_next = rdata;
                end
                if (ptr_reg < count_reg)
                begin
                    ptr_next = ptr_reg + CW'(1);
                    rdv_next = 1'b1;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            maxp_reg  <= 4'd8;
            rdv_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            rdv_reg   <= rdv_next;
            if (cfg_we)
                maxp_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg   <= ptr_next;
        wptr_reg  <= wptr_next;
        md_reg    <= md_next;
        cand_reg  <= cand_next;
        hit_reg   <= hit_next;
        hidx_reg  <= hidx_next;
        hent_reg  <= hent_next;
        worse_reg <= worse_next;
        widx_reg  <= widx_next;
        wrk_reg   <= wrk_next;
        best_reg  <= best_next;
        st_reg    <= st_next;
    end

    logic lk;
    logic pv;
    assign lk = (st_reg == ST_FOUND);
    assign pv = (count_reg != '0);

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = (state_reg == S_OUT);
    assign status        = st_reg;
    assign found_rank    = lk ? hent_reg.rk : 16'd0;
    assign found_dtsn    = lk ? hent_reg.ds : 8'd0;
    assign pref_valid    = pv;
    assign pref_neighbor = pv ? best_reg.nb : 16'd0;
    assign pref_dtsn     = pv ? best_reg.ds : 8'd0;
    assign dodag_rank    = pv ? ({1'b0, best_reg.rk} + 17'd1) : 17'd0;
    assign parent_count  = 4'(count_reg);
endmodule
`default_nettype wire
